[rtl/core/setq_pkg.sv]
package setq_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW     = $clog2(CAPACITY);

  localparam int unsigned FuncW    = 2;
  localparam int unsigned IdW      = 16;
  localparam int unsigned ExpW     = 32;
  localparam int unsigned StatW    = 3;
  localparam int unsigned CntOutW  = 5;

  localparam logic [FuncW-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FuncW-1:0] FUNC_ADJUST = 2'd1;
  localparam logic [FuncW-1:0] FUNC_DELETE = 2'd2;
  localparam logic [FuncW-1:0] FUNC_TICK   = 2'd3;

  localparam logic [StatW-1:0] ST_DONE     = 3'd0;
  localparam logic [StatW-1:0] ST_EXPIRED  = 3'd1;
  localparam logic [StatW-1:0] ST_FULL     = 3'd2;
  localparam logic [StatW-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [StatW-1:0] ST_DUP      = 3'd4;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [ExpW-1:0] expire;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

[rtl/core/setq_ram.sv]
module setq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/sorted_expiry_timer_queue.sv]
// Sorted timer queue holding up to CAPACITY timers (id and expiry) in one
// entry RAM, head first, ascending expiry as long as adjust only moves a
// timer later, equal expiries in arrival order. Items are taken one at a
// time; in_ready_o is high only while the block is idle, but a finished
// result may still wait at the output. The RAM read is registered, so each
// step over the RAM takes a read state and a second state: add, adjust and
// delete search the entries and then shift them, and tick reads each expired
// timer in turn and then compacts the rest with a shift. Expired results of a
// tick stall the walk when the output is not taken.
module sorted_expiry_timer_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [setq_pkg::FuncW-1:0]    func_i,
  input  logic [setq_pkg::IdW-1:0]      timer_id_i,
  input  logic [setq_pkg::ExpW-1:0]     expire_time_i,
  input  logic [setq_pkg::ExpW-1:0]     now_time_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [setq_pkg::StatW-1:0]    status_o,
  output logic [setq_pkg::IdW-1:0]      out_id_o,
  output logic [setq_pkg::ExpW-1:0]     out_expire_o,
  output logic [setq_pkg::CntOutW-1:0]  active_count_o,
  output logic                          last_o
);
  import setq_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_EV    = 4'd2;
  localparam logic [3:0] S_FIN   = 4'd3;
  localparam logic [3:0] S_TRD   = 4'd4;
  localparam logic [3:0] S_TEV   = 4'd5;
  localparam logic [3:0] S_TEND  = 4'd6;
  localparam logic [3:0] S_CPRD  = 4'd7;
  localparam logic [3:0] S_CPWR  = 4'd8;
  localparam logic [3:0] S_CPEND = 4'd9;
  localparam logic [3:0] S_WR    = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  localparam logic [CntW-1:0] CntOne = CntW'(1);
  localparam logic [CntW-1:0] CntCap = CntW'(CAPACITY);

  logic [3:0]       state_q, state_d;
  logic [FuncW-1:0] op_q, op_d;
  logic [IdW-1:0]   id_q, id_d;
  logic [ExpW-1:0]  ex_q, ex_d, now_q, now_d, fexp_q, fexp_d;
  logic [CntW-1:0]  count_q, count_d, idx_q, idx_d, pos_q, pos_d, p_q, p_d;
  logic [CntW-1:0]  src_q, src_d, n_q, n_d, off_q, off_d, wptr_q, wptr_d;
  logic             found_q, found_d, pfound_q, pfound_d, up_q, up_d;
  logic [StatW-1:0] rs_status_q, rs_status_d;
  logic [IdW-1:0]   rs_id_q, rs_id_d;
  logic [ExpW-1:0]  rs_exp_q, rs_exp_d;

  logic               ovalid_q, ovalid_d, olast_q, olast_d;
  logic [StatW-1:0]   ostat_q, ostat_d;
  logic [IdW-1:0]     oid_q, oid_d;
  logic [ExpW-1:0]    oexp_q, oexp_d;
  logic [CntOutW-1:0] ocnt_q, ocnt_d;

  logic            ram_we, ram_re;
  logic [IdxW-1:0] ram_waddr, ram_raddr;
  entry_t          ram_wdata, rd;
  logic [CntW-1:0] dst;
  logic            out_free;

  setq_ram #(
    .Width (EntryW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd)
  );

  assign out_free = !ovalid_q || out_ready_i;
  assign dst      = up_q ? (src_q + CntOne) : (src_q - off_q);

  always_comb begin
    state_d = state_q;  op_d = op_q;  id_d = id_q;  ex_d = ex_q;  now_d = now_q;
    fexp_d = fexp_q;  count_d = count_q;  idx_d = idx_q;  pos_d = pos_q;
    p_d = p_q;  src_d = src_q;  n_d = n_q;  off_d = off_q;  wptr_d = wptr_q;
    found_d = found_q;  pfound_d = pfound_q;  up_d = up_q;
    rs_status_d = rs_status_q;  rs_id_d = rs_id_q;  rs_exp_d = rs_exp_q;
    ovalid_d = ovalid_q;  olast_d = olast_q;  ostat_d = ostat_q;
    oid_d = oid_q;  oexp_d = oexp_q;  ocnt_d = ocnt_q;
    ram_we = 1'b0;  ram_re = 1'b0;
    ram_waddr = wptr_q[IdxW-1:0];
    ram_raddr = idx_q[IdxW-1:0];
    ram_wdata = rd;

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d = func_i;  id_d = timer_id_i;  ex_d = expire_time_i;
          now_d = now_time_i;  idx_d = '0;  found_d = 1'b0;
          pfound_d = 1'b0;  p_d = '0;
          state_d = (func_i == FUNC_TICK) ? S_TRD : S_RD;
        end
      end
      S_RD: begin
        if (idx_q < count_q) begin
          ram_re = 1'b1;
          state_d = S_EV;
        end else begin
          state_d = S_FIN;
        end
      end
      S_EV: begin
        idx_d = idx_q + CntOne;
        state_d = S_RD;
        case (op_q)
          FUNC_ADD: begin
            if (rd.id == id_q) begin
              rs_status_d = ST_DUP;  rs_id_d = id_q;  rs_exp_d = rd.expire;
              state_d = S_OUT;
            end else if (!pfound_q && (ex_q < rd.expire)) begin
              pfound_d = 1'b1;  p_d = idx_q;
            end
          end
          FUNC_DELETE: begin
            if (rd.id == id_q) begin
              fexp_d = rd.expire;  src_d = idx_q + CntOne;
              n_d = count_q - idx_q - CntOne;  up_d = 1'b0;  off_d = CntOne;
              state_d = S_CPRD;
            end
          end
          FUNC_ADJUST: begin
            if (!found_q) begin
              if (rd.id == id_q) begin
                found_d = 1'b1;  pos_d = idx_q;
              end
            end else if (ex_q < rd.expire) begin
              if (idx_q == pos_q + CntOne) begin
                // new time stays below the successor: rewrite in place
                wptr_d = pos_q;
                state_d = S_WR;
              end else begin
                // shift the passed entries down and drop the timer behind them
                src_d = pos_q + CntOne;  n_d = idx_q - pos_q - CntOne;
                up_d = 1'b0;  off_d = CntOne;  wptr_d = idx_q - CntOne;
                state_d = S_CPRD;
              end
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_FIN: begin
        state_d = S_OUT;
        case (op_q)
          FUNC_ADD: begin
            if (count_q == CntCap) begin
              rs_status_d = ST_FULL;  rs_id_d = id_q;  rs_exp_d = ex_q;
            end else begin
              p_d = pfound_q ? p_q : count_q;
              src_d = count_q - CntOne;
              n_d = count_q - (pfound_q ? p_q : count_q);
              up_d = 1'b1;  off_d = CntOne;
              state_d = S_CPRD;
            end
          end
          FUNC_ADJUST: begin
            if (!found_q) begin
              rs_status_d = ST_NOTFOUND;  rs_id_d = id_q;  rs_exp_d = '0;
            end else if (pos_q + CntOne == count_q) begin
              wptr_d = pos_q;
              state_d = S_WR;
            end else begin
              src_d = pos_q + CntOne;  n_d = count_q - pos_q - CntOne;
              up_d = 1'b0;  off_d = CntOne;  wptr_d = count_q - CntOne;
              state_d = S_CPRD;
            end
          end
          default: begin
            rs_status_d = ST_NOTFOUND;  rs_id_d = id_q;  rs_exp_d = '0;
          end
        endcase
      end
      S_TRD: begin
        if (idx_q < count_q) begin
          ram_re = 1'b1;
          state_d = S_TEV;
        end else begin
          state_d = S_TEND;
        end
      end
      S_TEV: begin
        if (!(now_q < rd.expire)) begin
          // hold the entry until the output register frees up
          if (out_free) begin
            ovalid_d = 1'b1;  ostat_d = ST_EXPIRED;  oid_d = rd.id;
            oexp_d = rd.expire;  olast_d = 1'b0;
            ocnt_d = CntOutW'(count_q - idx_q - CntOne);
            idx_d = idx_q + CntOne;
            state_d = S_TRD;
          end
        end else begin
          state_d = S_TEND;
        end
      end
      S_TEND: begin
        src_d = idx_q;  n_d = count_q - idx_q;  off_d = idx_q;  up_d = 1'b0;
        state_d = S_CPRD;
      end
      S_CPRD: begin
        if (n_q == '0) begin
          state_d = S_CPEND;
        end else begin
          ram_re = 1'b1;
          ram_raddr = src_q[IdxW-1:0];
          state_d = S_CPWR;
        end
      end
      S_CPWR: begin
        ram_we = 1'b1;
        ram_waddr = dst[IdxW-1:0];
        ram_wdata = rd;
        src_d = up_q ? (src_q - CntOne) : (src_q + CntOne);
        n_d = n_q - CntOne;
        state_d = S_CPRD;
      end
      S_CPEND: begin
        state_d = S_OUT;
        case (op_q)
          FUNC_ADD: begin
            count_d = count_q + CntOne;  wptr_d = p_q;
            state_d = S_WR;
          end
          FUNC_ADJUST: state_d = S_WR;
          FUNC_DELETE: begin
            count_d = count_q - CntOne;
            rs_status_d = ST_DONE;  rs_id_d = id_q;  rs_exp_d = fexp_q;
          end
          default: begin
            count_d = count_q - off_q;
            rs_status_d = ST_DONE;  rs_id_d = '0;  rs_exp_d = '0;
          end
        endcase
      end
      S_WR: begin
        ram_we = 1'b1;
        ram_wdata.id = id_q;
        ram_wdata.expire = ex_q;
        rs_status_d = ST_DONE;  rs_id_d = id_q;  rs_exp_d = ex_q;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          ovalid_d = 1'b1;  ostat_d = rs_status_q;  oid_d = rs_id_q;
          oexp_d = rs_exp_q;  olast_d = 1'b1;  ocnt_d = CntOutW'(count_q);
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;  id_q <= id_d;  ex_q <= ex_d;  now_q <= now_d;
    fexp_q <= fexp_d;  idx_q <= idx_d;  pos_q <= pos_d;  p_q <= p_d;
    src_q <= src_d;  n_q <= n_d;  off_q <= off_d;  wptr_q <= wptr_d;
    found_q <= found_d;  pfound_q <= pfound_d;  up_q <= up_d;
    rs_status_q <= rs_status_d;  rs_id_q <= rs_id_d;  rs_exp_q <= rs_exp_d;
    olast_q <= olast_d;  ostat_q <= ostat_d;  oid_q <= oid_d;
    oexp_q <= oexp_d;  ocnt_q <= ocnt_d;
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = ovalid_q;
  assign status_o       = ostat_q;
  assign out_id_o       = oid_q;
  assign out_expire_o   = oexp_q;
  assign active_count_o = ocnt_q;
  assign last_o         = olast_q;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntCap) else $error("timer count above capacity");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (CntW'(ram_waddr) <= count_q))
    else $error("entry write beyond the held entries");

  a_expired_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && ostat_q == ST_EXPIRED) |-> !olast_q)
    else $error("expired result marked last");

  a_count_idle_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> (count_q == $past(count_q)))
    else $error("timer count changed while idle");
`endif

endmodule
